FILE: src/circle_segment_intersection_unit_assert.svh
// Assertion macros for the circle segment intersection unit.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef CIRCLE_SEGMENT_INTERSECTION_UNIT_ASSERT_SVH
`define CIRCLE_SEGMENT_INTERSECTION_UNIT_ASSERT_SVH

// same-cycle implication
`define CSI_ASSERT_IMP(LBL, ANT, CON, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |-> (CON)) \
        else $error(MSG);

// next-cycle implication
`define CSI_ASSERT_NXT(LBL, ANT, CON, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |=> (CON)) \
        else $error(MSG);

`endif

FILE: src/csi_pkg.sv
// Shared types, constants and step functions of the circle segment intersection unit.
// No dependencies.
package csi_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CNT_W      = 3;
    localparam int ROOT_STEPS = 64;
    localparam int DIV_STEPS  = 32;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    // classified transaction handed from front to back
    typedef struct packed {
        logic        zero;
        logic        pos;
        logic        dx_neg;
        logic [32:0] dx_mag;
        logic        dy_neg;
        logic [32:0] dy_mag;
        logic        d_neg;
        logic [63:0] d_mag;
        logic [65:0] dr2;
        logic [30:0] r;
    } t_job;

    typedef struct packed {
        t_status      st;
        logic         pos;
        logic         dx_neg;
        logic [32:0]  dx_mag;
        logic         dy_neg;
        logic [32:0]  dy_mag;
        logic         d_neg;
        logic [63:0]  d_mag;
        logic [65:0]  dr2;
        logic [127:0] rad;
        logic [65:0]  rem;
        logic [63:0]  root;
    } t_root;

    typedef struct packed {
        logic        v;
        t_status     st;
        logic [98:0] nx;
        logic [98:0] ny;
        logic [65:0] dr2;
    } t_dreq;

    typedef struct packed {
        logic [65:0] rem;
        logic [31:0] low;
        logic [31:0] q;
    } t_lane;

    typedef struct packed {
        t_status     st;
        logic        x_neg;
        logic        x_big;
        logic        y_neg;
        logic        y_big;
        t_lane       x;
        t_lane       y;
        logic [65:0] dr2;
    } t_dstage;

    // one bit of the integer square root, from two radicand bits
    function automatic t_root root_step(t_root a);
        t_root       r;
        logic [67:0] acc;
        logic [67:0] trial;
        r     = a;
        acc   = {a.rem, a.rad[127:126]};
        trial = {2'b00, a.root, 2'b01};
        if (acc >= trial) begin
            r.rem  = 66'(acc - trial);
            r.root = {a.root[62:0], 1'b1};
        end else begin
            r.rem  = acc[65:0];
            r.root = {a.root[62:0], 1'b0};
        end
        r.rad = {a.rad[125:0], 2'b00};
        return r;
    endfunction

    // one restoring division step
    function automatic t_lane lane_step(t_lane a, logic [65:0] d);
        t_lane       r;
        logic [66:0] acc;
        acc = {a.rem, a.low[31]};
        if (acc >= {1'b0, d}) begin
            r.rem = 66'(acc - {1'b0, d});
            r.q   = {a.q[30:0], 1'b1};
        end else begin
            r.rem = acc[65:0];
            r.q   = {a.q[30:0], 1'b0};
        end
        r.low = {a.low[30:0], 1'b0};
        return r;
    endfunction

    // round half away from zero, saturate, apply sign
    function automatic logic [31:0] lane_result(t_lane a, logic neg, logic big,
                                               logic [65:0] d);
        logic [32:0] q;
        logic [32:0] lim;
        q   = {1'b0, a.q} + 33'(({a.rem, 1'b0} >= {1'b0, d}) ? 1 : 0);
        lim = neg ? 33'h080000000 : 33'h07FFFFFFF;
        if (big || q > lim) begin
            q = lim;
        end
        return neg ? 32'(33'd0 - q) : q[31:0];
    endfunction

    function automatic logic [98:0] to_signed99(logic neg, logic [96:0] mag);
        logic [98:0] v;
        v = {2'b00, mag};
        return neg ? 99'(99'd0 - v) : v;
    endfunction

endpackage

FILE: src/csi_front.sv
// Front end: registers accepted transactions, forms differences, cross and square terms,
// flags zero-length segments. Depends on csi_pkg.
module csi_front import csi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic        [30:0] i_lookahead_radius,
    output logic               o_push,
    output t_job               o_job,
    output logic        [1:0]  o_inflight
);

    logic               r_s0_v, r_s1_v, r_s2_v;
    logic signed [31:0] r_x1, r_y1, r_x2, r_y2;
    logic        [30:0] r_r0, r_r1, r_r2;
    logic signed [32:0] r_dx1, r_dy1, r_dx2, r_dy2;
    logic signed [63:0] r_p1, r_p2;
    logic        [63:0] r_qx1, r_qy1, r_qx2, r_qy2;
    logic signed [64:0] r_d;
    logic        [65:0] r_dxsq, r_dysq;
    logic        [63:0] r_n1, r_n2;
    logic               r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s0_v <= i_accept;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1 <= i_start_x;
        r_y1 <= i_start_y;
        r_x2 <= i_end_x;
        r_y2 <= i_end_y;
        r_r0 <= i_lookahead_radius;

        r_dx1 <= 33'(r_x2) - 33'(r_x1);
        r_dy1 <= 33'(r_y2) - 33'(r_y1);
        r_p1  <= 64'(r_x1) * 64'(r_y2);
        r_p2  <= 64'(r_x2) * 64'(r_y1);
        r_qx1 <= 64'(r_x1) * 64'(r_x1);
        r_qy1 <= 64'(r_y1) * 64'(r_y1);
        r_qx2 <= 64'(r_x2) * 64'(r_x2);
        r_qy2 <= 64'(r_y2) * 64'(r_y2);
        r_r1  <= r_r0;

        r_d    <= 65'(r_p1) - 65'(r_p2);
        r_dxsq <= 66'(66'(r_dx1) * 66'(r_dx1));
        r_dysq <= 66'(66'(r_dy1) * 66'(r_dy1));
        r_n1   <= r_qx1 + r_qy1;
        r_n2   <= r_qx2 + r_qy2;
        r_zero <= (r_dx1 == 33'sd0) && (r_dy1 == 33'sd0);
        r_dx2  <= r_dx1;
        r_dy2  <= r_dy1;
        r_r2   <= r_r1;
    end

    always_comb begin
        o_job.zero   = r_zero;
        o_job.pos    = r_n2 >= r_n1;
        o_job.dx_neg = r_dx2[32];
        o_job.dx_mag = r_dx2[32] ? 33'(33'd0 - r_dx2) : r_dx2;
        o_job.dy_neg = r_dy2[32];
        o_job.dy_mag = r_dy2[32] ? 33'(33'd0 - r_dy2) : r_dy2;
        o_job.d_neg  = r_d[64];
        o_job.d_mag  = r_d[64] ? 64'(65'd0 - r_d) : r_d[63:0];
        o_job.dr2    = r_dxsq + r_dysq;
        o_job.r      = r_r2;
    end

    assign o_push     = r_s2_v;
    assign o_inflight = 2'(r_s0_v) + 2'(r_s1_v) + 2'(r_s2_v);

endmodule

FILE: src/csi_fifo.sv
// Small queue between front and back end; back end drains one transaction per cycle.
// Depends on csi_pkg and the assertion macro header.
`include "circle_segment_intersection_unit_assert.svh"
module csi_fifo import csi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_job       i_data,
    input  logic [1:0] i_inflight,
    output logic       o_busy,
    output logic       o_pop,
    output t_job       o_data
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [CNT_W-1:0]   r_count;

    assign o_pop  = r_count != '0;
    assign o_data = r_mem[r_rd];
    // entry popped this cycle is already free
    assign o_busy = (4'(r_count) - 4'(o_pop) + 4'(i_inflight)) >= 4'(FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (o_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(o_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `CSI_ASSERT_IMP(a_no_overflow, i_push && !o_pop, r_count != CNT_W'(FIFO_DEPTH), "queue overflow")
    `CSI_ASSERT_IMP(a_room_when_ready, !o_busy, r_count < CNT_W'(FIFO_DEPTH), "ready with full queue")
    `CSI_ASSERT_NXT(a_count_up, i_push && !o_pop, r_count == CNT_W'($past(r_count) + 1'b1), "count slip")

endmodule

FILE: src/csi_back.sv
// Back end: discriminant, pipelined integer square root and numerator products.
// Depends on csi_pkg.
module csi_back import csi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_pop,
    input  t_job  i_job,
    output t_dreq o_req
);

    logic         r_b0_v, r_b1_v, r_b2_v;
    t_job         r_j0, r_j1, r_j2;
    logic [61:0]  r_rr;
    logic [63:0]  r_dhh, r_dhl, r_dll;
    logic [127:0] r_dsq1, r_dsq2, r_rd;
    logic [63:0]  r_phh, r_pll;
    logic [61:0]  r_phl;
    logic [65:0]  r_plh;

    logic [ROOT_STEPS:0] r_rt_v;
    t_root               r_rt [ROOT_STEPS+1];
    t_root               n_rt0;
    logic [128:0]        n_disc;
    t_root               w_rl;

    logic        r_m1_v, r_m2_v, r_m3_v;
    t_status     r_m1_st, r_m2_st, r_m3_st;
    logic [65:0] r_m1_dr2, r_m2_dr2, r_m3_dr2;
    logic        r_m1_sx, r_m1_sy, r_m1_sxs, r_m1_sys;
    logic        r_m2_sx, r_m2_sy, r_m2_sxs, r_m2_sys;
    logic [64:0] r_a0, r_a1, r_b0, r_b1, r_c0, r_c1, r_e0, r_e1;
    logic [96:0] r_pddy, r_pddx, r_pdxs, r_pdys;
    logic [98:0] r_nx, r_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_v <= 1'b0;
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_rt_v <= '0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
        end else begin
            r_b0_v <= i_pop;
            r_b1_v <= r_b0_v;
            r_b2_v <= r_b1_v;
            r_rt_v <= {r_rt_v[ROOT_STEPS-1:0], r_b2_v};
            r_m1_v <= r_rt_v[ROOT_STEPS];
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
        end
    end

    // r^2, |D|^2 and r^2 * dr2 partials
    always_ff @(posedge i_clk) begin
        r_j0  <= i_job;
        r_rr  <= 62'(i_job.r) * 62'(i_job.r);
        r_dhh <= 64'(i_job.d_mag[63:32]) * 64'(i_job.d_mag[63:32]);
        r_dhl <= 64'(i_job.d_mag[63:32]) * 64'(i_job.d_mag[31:0]);
        r_dll <= 64'(i_job.d_mag[31:0]) * 64'(i_job.d_mag[31:0]);

        r_j1   <= r_j0;
        r_dsq1 <= {r_dhh, 64'd0} + {31'd0, r_dhl, 33'd0} + {64'd0, r_dll};
        r_phh  <= 64'(r_rr[61:32]) * 64'(r_j0.dr2[65:32]);
        r_phl  <= 62'(r_rr[61:32]) * 62'(r_j0.dr2[31:0]);
        r_plh  <= 66'(r_rr[31:0]) * 66'(r_j0.dr2[65:32]);
        r_pll  <= 64'(r_rr[31:0]) * 64'(r_j0.dr2[31:0]);

        r_j2   <= r_j1;
        r_dsq2 <= r_dsq1;
        r_rd   <= {r_phh, 64'd0} + {34'd0, r_phl, 32'd0} + {30'd0, r_plh, 32'd0}
                  + {64'd0, r_pll};
    end

    always_comb begin
        n_disc       = {1'b0, r_rd} - {1'b0, r_dsq2};
        n_rt0.st     = r_j2.zero ? ST_ZERO : (n_disc[128] ? ST_MISS : ST_OK);
        n_rt0.pos    = r_j2.pos;
        n_rt0.dx_neg = r_j2.dx_neg;
        n_rt0.dx_mag = r_j2.dx_mag;
        n_rt0.dy_neg = r_j2.dy_neg;
        n_rt0.dy_mag = r_j2.dy_mag;
        n_rt0.d_neg  = r_j2.d_neg;
        n_rt0.d_mag  = r_j2.d_mag;
        n_rt0.dr2    = r_j2.dr2;
        n_rt0.rad    = n_disc[127:0];
        n_rt0.rem    = '0;
        n_rt0.root   = '0;
    end

    always_ff @(posedge i_clk) begin
        r_rt[0] <= n_rt0;
        for (int k = 1; k <= ROOT_STEPS; k++) begin
            r_rt[k] <= root_step(r_rt[k-1]);
        end
    end

    assign w_rl = r_rt[ROOT_STEPS];

    always_ff @(posedge i_clk) begin
        r_m1_st  <= w_rl.st;
        r_m1_dr2 <= w_rl.dr2;
        r_m1_sx  <= w_rl.d_neg ^ w_rl.dy_neg;
        r_m1_sy  <= !(w_rl.d_neg ^ w_rl.dx_neg);
        r_m1_sxs <= w_rl.dx_neg ^ !w_rl.pos;
        r_m1_sys <= w_rl.dy_neg ^ !w_rl.pos;
        r_a0 <= 65'(w_rl.d_mag[63:32]) * 65'(w_rl.dy_mag);
        r_a1 <= 65'(w_rl.d_mag[31:0]) * 65'(w_rl.dy_mag);
        r_b0 <= 65'(w_rl.d_mag[63:32]) * 65'(w_rl.dx_mag);
        r_b1 <= 65'(w_rl.d_mag[31:0]) * 65'(w_rl.dx_mag);
        r_c0 <= 65'(w_rl.root[63:32]) * 65'(w_rl.dx_mag);
        r_c1 <= 65'(w_rl.root[31:0]) * 65'(w_rl.dx_mag);
        r_e0 <= 65'(w_rl.root[63:32]) * 65'(w_rl.dy_mag);
        r_e1 <= 65'(w_rl.root[31:0]) * 65'(w_rl.dy_mag);

        r_m2_st  <= r_m1_st;
        r_m2_dr2 <= r_m1_dr2;
        r_m2_sx  <= r_m1_sx;
        r_m2_sy  <= r_m1_sy;
        r_m2_sxs <= r_m1_sxs;
        r_m2_sys <= r_m1_sys;
        r_pddy <= {r_a0, 32'd0} + {32'd0, r_a1};
        r_pddx <= {r_b0, 32'd0} + {32'd0, r_b1};
        r_pdxs <= {r_c0, 32'd0} + {32'd0, r_c1};
        r_pdys <= {r_e0, 32'd0} + {32'd0, r_e1};

        r_m3_st  <= r_m2_st;
        r_m3_dr2 <= r_m2_dr2;
        r_nx <= to_signed99(r_m2_sx, r_pddy) + to_signed99(r_m2_sxs, r_pdxs);
        r_ny <= to_signed99(r_m2_sy, r_pddx) + to_signed99(r_m2_sys, r_pdys);
    end

    always_comb begin
        o_req.v   = r_m3_v;
        o_req.st  = r_m3_st;
        o_req.nx  = r_nx;
        o_req.ny  = r_ny;
        o_req.dr2 = r_m3_dr2;
    end

endmodule

FILE: src/csi_div.sv
// Pipelined restoring dividers for both coordinates, rounding and saturation.
// Depends on csi_pkg.
module csi_div import csi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dreq              i_req,
    output logic               o_done,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic        [1:0]  o_status
);

    logic [DIV_STEPS:0] r_d_v;
    t_dstage            r_d [DIV_STEPS+1];
    t_dstage            n_d0;
    t_dstage            w_last;
    logic [98:0]        n_xmag, n_ymag, n_lim;

    // one quotient bit on both lanes
    function automatic t_dstage div_step(t_dstage a);
        t_dstage r;
        r   = a;
        r.x = lane_step(a.x, a.dr2);
        r.y = lane_step(a.y, a.dr2);
        return r;
    endfunction

    always_comb begin
        n_xmag       = i_req.nx[98] ? 99'(99'd0 - i_req.nx) : i_req.nx;
        n_ymag       = i_req.ny[98] ? 99'(99'd0 - i_req.ny) : i_req.ny;
        n_lim        = {1'b0, i_req.dr2, 32'd0};
        n_d0.st      = i_req.st;
        n_d0.x_neg   = i_req.nx[98];
        n_d0.y_neg   = i_req.ny[98];
        n_d0.x_big   = n_xmag >= n_lim;
        n_d0.y_big   = n_ymag >= n_lim;
        n_d0.x.rem   = n_xmag[97:32];
        n_d0.x.low   = n_xmag[31:0];
        n_d0.x.q     = '0;
        n_d0.y.rem   = n_ymag[97:32];
        n_d0.y.low   = n_ymag[31:0];
        n_d0.y.q     = '0;
        n_d0.dr2     = i_req.dr2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v  <= '0;
            o_done <= 1'b0;
        end else begin
            r_d_v  <= {r_d_v[DIV_STEPS-1:0], i_req.v};
            o_done <= r_d_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d[0] <= n_d0;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            r_d[k] <= div_step(r_d[k-1]);
        end
    end

    assign w_last = r_d[DIV_STEPS];

    always_ff @(posedge i_clk) begin
        o_status <= w_last.st;
        if (w_last.st == ST_OK) begin
            o_point_x <= lane_result(w_last.x, w_last.x_neg, w_last.x_big, w_last.dr2);
            o_point_y <= lane_result(w_last.y, w_last.y_neg, w_last.y_big, w_last.dr2);
        end else begin
            o_point_x <= '0;
            o_point_y <= '0;
        end
    end

endmodule

FILE: src/circle_segment_intersection_unit.sv
// A result strobes on o_done after passing the front end, queue, back end and dividers.
// Throughput: one transaction per cycle; set by the fully pipelined 64-step square root
// and the two 32-step dividers. busy rises only if the front-to-back queue cannot take
// all transactions in flight. Synchronous active-low reset clears all valid bits and the
// queue; results are never held back by the receiver.
module circle_segment_intersection_unit import csi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic        [30:0] i_lookahead_radius,
    output logic               o_done,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic        [1:0]  o_status
);

    logic       w_accept;
    logic       w_push;
    logic       w_pop;
    logic [1:0] w_inflight;
    t_job       w_job_in;
    t_job       w_job_out;
    t_dreq      w_req;

    assign w_accept = start && !busy;

    csi_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (w_accept),
        .i_start_x          (i_start_x),
        .i_start_y          (i_start_y),
        .i_end_x            (i_end_x),
        .i_end_y            (i_end_y),
        .i_lookahead_radius (i_lookahead_radius),
        .o_push             (w_push),
        .o_job              (w_job_in),
        .o_inflight         (w_inflight)
    );

    csi_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_job_in),
        .i_inflight (w_inflight),
        .o_busy     (busy),
        .o_pop      (w_pop),
        .o_data     (w_job_out)
    );

    csi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pop   (w_pop),
        .i_job   (w_job_out),
        .o_req   (w_req)
    );

    csi_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_done    (o_done),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_status  (o_status)
    );

endmodule
